// File: src/bmdf_pkg.sv
package bmdf_pkg;

    // Message layout
    localparam int unsigned PRE_BYTES   = 16;
    localparam logic [7:0]  SIG_CODE    = 8'h08;
    localparam int unsigned ALIGN       = 8;
    localparam int unsigned LEN_FIELD   = 4;

    // Lengths keep only their low LENGTH_BITS bits (8 to 32).
    localparam int unsigned LENGTH_BITS = 32;
    localparam logic [31:0] LEN_MASK    = 32'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [31:0] HDR_MAX     = 32'hFFFF_FFF8;

    // Parser phases
    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Byte roles
    localparam logic [3:0] ROLE_PRE      = 4'd0;
    localparam logic [3:0] ROLE_CODE     = 4'd1;
    localparam logic [3:0] ROLE_RESERVED = 4'd2;
    localparam logic [3:0] ROLE_STRLEN   = 4'd3;
    localparam logic [3:0] ROLE_STRING   = 4'd4;
    localparam logic [3:0] ROLE_SIGCOUNT = 4'd5;
    localparam logic [3:0] ROLE_SIG      = 4'd6;
    localparam logic [3:0] ROLE_PAD      = 4'd7;
    localparam logic [3:0] ROLE_BODYLEN  = 4'd8;
    localparam logic [3:0] ROLE_BODYDATA = 4'd9;

    // Word queue between the front and the parser; the depth is a power of two.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } queue_head_t;

    function automatic logic [31:0] put_byte(input logic [31:0] v, input logic [7:0] b,
                                             input logic [1:0] idx);
        logic [31:0] r;
        r = v;
        r[{idx, 3'b000} +: 8] = b;
        return r;
    endfunction

    function automatic logic [33:0] round8(input logic [33:0] v);
        logic [33:0] s;
        s = v + 34'(ALIGN - 1);
        return s & ~34'(ALIGN - 1);
    endfunction

endpackage

// File: src/bmdf_queue.sv
module bmdf_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  logic [7:0]             push_data,
    output logic                   full,
    output bmdf_pkg::queue_head_t  head,
    input  logic                   pop
);

    logic [7:0]                      mem_reg [bmdf_pkg::QUEUE_DEPTH];
    logic [bmdf_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [bmdf_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [bmdf_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [bmdf_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [bmdf_pkg::QPTR_W:0]       count_reg;
    logic [bmdf_pkg::QPTR_W:0]       count_next;
    logic                            push;
    logic                            do_pop;

    assign full   = (count_reg == (bmdf_pkg::QPTR_W + 1)'(bmdf_pkg::QUEUE_DEPTH));
    assign push   = push_valid && !full;
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/bmdf_parser.sv
module bmdf_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bmdf_pkg::queue_head_t  head,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [3:0]             byte_role,
    output logic [7:0]             field_code,
    output logic [7:0]             signature_count,
    output logic [31:0]            msg_identifier,
    output logic [31:0]            body_bytes,
    output logic [31:0]            header_bytes,
    output logic [32:0]            entry_bytes,
    output logic                   field_end,
    output logic                   message_end
);

    logic [1:0]  phase_reg,  phase_next;
    logic [31:0] ppos_reg,   ppos_next;
    logic [32:0] fpos_reg,   fpos_next;
    logic [33:0] ftot_reg,   ftot_next;
    logic [7:0]  code_reg,   code_next;
    logic [31:0] id_reg,     id_next;
    logic [31:0] blen_reg,   blen_next;
    logic [31:0] hlen_reg,   hlen_next;
    logic [7:0]  count_reg,  count_next;
    logic [32:0] elen_reg,   elen_next;
    logic        valid_reg,  valid_next;
    logic [3:0]  role_reg,   role_next;
    logic        fend_reg,   fend_next;
    logic        mend_reg,   mend_next;

    // The state moves only when a word leaves the queue, and that is also when the
    // result slot is loaded, so the held fields come straight from the state.
    assign pop = head.valid && (!valid_reg || !result_stall);

    always_comb
    begin
        logic [7:0]  b;
        logic [32:0] p;
        logic [3:0]  p4;
        logic [31:0] ins;
        logic [31:0] pp;
        logic [31:0] blen_put;
        logic [31:0] hlen_put;
        logic [31:0] h;

        b           = head.data;
        p           = fpos_reg;
        p4          = ppos_reg[3:0];
        ins         = '0;
        pp          = ppos_reg + 32'd1;
        blen_put    = blen_reg;
        hlen_put    = hlen_reg;
        h           = '0;

        phase_next  = phase_reg;
        ppos_next   = ppos_reg;
        fpos_next   = fpos_reg;
        ftot_next   = ftot_reg;
        code_next   = code_reg;
        id_next     = id_reg;
        blen_next   = blen_reg;
        hlen_next   = hlen_reg;
        count_next  = count_reg;
        elen_next   = elen_reg;
        role_next   = bmdf_pkg::ROLE_PRE;
        fend_next   = 1'b0;
        mend_next   = 1'b0;

        case (phase_reg)
            bmdf_pkg::PH_HDR:
            begin
                if (p == '0)
                begin
                    code_next = b;
                    elen_next = '0;
                    ftot_next = '0;
                    role_next = bmdf_pkg::ROLE_CODE;
                end
                else if (p < 33'd4)
                begin
                    role_next = bmdf_pkg::ROLE_RESERVED;
                end
                else if (code_reg == bmdf_pkg::SIG_CODE)
                begin
                    if (p == 33'd4)
                    begin
                        count_next = b;
                        elen_next  = {25'd0, b} + 33'd1;
                        ftot_next  = bmdf_pkg::round8({26'd0, b} + 34'd6);
                        role_next  = bmdf_pkg::ROLE_SIGCOUNT;
                    end
                    else if ({1'b0, p} < {1'b0, elen_reg} + 34'd5)
                    begin
                        role_next = bmdf_pkg::ROLE_SIG;
                    end
                    else
                    begin
                        role_next = bmdf_pkg::ROLE_PAD;
                    end
                end
                else if (p < 33'd8)
                begin
                    // Length bytes 4 to 7 land in byte lanes 0 to 3.
                    role_next = bmdf_pkg::ROLE_STRLEN;
                    ins = bmdf_pkg::put_byte(elen_reg[31:0], b, p[1:0]);
                    if (p == 33'd7)
                    begin
                        elen_next = {1'b0, ins & bmdf_pkg::LEN_MASK} + 33'd1;
                        ftot_next = bmdf_pkg::round8({1'b0, elen_next}) + 34'd8;
                    end
                    else
                    begin
                        elen_next = {1'b0, ins};
                    end
                end
                else if ({1'b0, p} < {1'b0, elen_reg} + 34'd8)
                begin
                    role_next = bmdf_pkg::ROLE_STRING;
                end
                else
                begin
                    role_next = bmdf_pkg::ROLE_PAD;
                end

                fpos_next = p + 33'd1;
                if (ftot_next != '0 && {1'b0, fpos_next} >= ftot_next)
                begin
                    fend_next = 1'b1;
                    fpos_next = '0;
                end
                ppos_next = pp;
                if (pp >= hlen_reg)
                begin
                    fend_next = 1'b1;
                    fpos_next = '0;
                    ftot_next = '0;
                    ppos_next = '0;
                    if (blen_reg == '0)
                    begin
                        mend_next  = 1'b1;
                        phase_next = bmdf_pkg::PH_PRE;
                    end
                    else
                    begin
                        phase_next = bmdf_pkg::PH_BODY;
                    end
                end
            end

            bmdf_pkg::PH_BODY:
            begin
                if (p < 33'(bmdf_pkg::LEN_FIELD))
                begin
                    role_next = bmdf_pkg::ROLE_BODYLEN;
                    if (p == '0)
                    begin
                        ftot_next = '0;
                        ins = bmdf_pkg::put_byte(32'd0, b, p[1:0]);
                    end
                    else
                    begin
                        ins = bmdf_pkg::put_byte(elen_reg[31:0], b, p[1:0]);
                    end
                    if (p == 33'(bmdf_pkg::LEN_FIELD - 1))
                    begin
                        elen_next = {1'b0, ins & bmdf_pkg::LEN_MASK} + 33'd1;
                        ftot_next = {1'b0, elen_next} + 34'(bmdf_pkg::LEN_FIELD);
                    end
                    else
                    begin
                        elen_next = {1'b0, ins};
                    end
                end
                else
                begin
                    role_next = bmdf_pkg::ROLE_BODYDATA;
                end

                fpos_next = p + 33'd1;
                if (ftot_next != '0 && {1'b0, fpos_next} >= ftot_next)
                begin
                    fend_next = 1'b1;
                    fpos_next = '0;
                end
                ppos_next = pp;
                if (pp >= blen_reg)
                begin
                    fend_next  = 1'b1;
                    mend_next  = 1'b1;
                    fpos_next  = '0;
                    ftot_next  = '0;
                    ppos_next  = '0;
                    phase_next = bmdf_pkg::PH_PRE;
                end
            end

            default:
            begin
                // Preheader: bytes 0 to 3 carry nothing that is kept.
                if (p4 inside {[4'd4:4'd7]})
                begin
                    blen_put = bmdf_pkg::put_byte(blen_reg, b, p4[1:0]);
                end
                else if (p4 inside {[4'd8:4'd11]})
                begin
                    id_next = bmdf_pkg::put_byte(id_reg, b, p4[1:0]);
                end
                else if (p4 >= 4'd12)
                begin
                    hlen_put = bmdf_pkg::put_byte(hlen_reg, b, p4[1:0]);
                end
                blen_next  = blen_put;
                hlen_next  = hlen_put;
                ppos_next  = {28'd0, p4} + 32'd1;
                phase_next = bmdf_pkg::PH_PRE;
                if (p4 == 4'(bmdf_pkg::PRE_BYTES - 1))
                begin
                    h         = hlen_put & bmdf_pkg::LEN_MASK;
                    blen_next = blen_put & bmdf_pkg::LEN_MASK;
                    if (h > bmdf_pkg::HDR_MAX)
                    begin
                        hlen_next = bmdf_pkg::HDR_MAX;
                    end
                    else
                    begin
                        hlen_next = 32'(bmdf_pkg::round8({2'd0, h}));
                    end
                    ppos_next = '0;
                    fpos_next = '0;
                    ftot_next = '0;
                    if (hlen_next != '0)
                    begin
                        phase_next = bmdf_pkg::PH_HDR;
                    end
                    else if (blen_next != '0)
                    begin
                        phase_next = bmdf_pkg::PH_BODY;
                    end
                    else
                    begin
                        mend_next = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bmdf_pkg::PH_PRE;
            ppos_reg  <= '0;
            fpos_reg  <= '0;
            ftot_reg  <= '0;
            code_reg  <= '0;
            id_reg    <= '0;
            blen_reg  <= '0;
            hlen_reg  <= '0;
            count_reg <= '0;
            elen_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                ppos_reg  <= ppos_next;
                fpos_reg  <= fpos_next;
                ftot_reg  <= ftot_next;
                code_reg  <= code_next;
                id_reg    <= id_next;
                blen_reg  <= blen_next;
                hlen_reg  <= hlen_next;
                count_reg <= count_next;
                elen_reg  <= elen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            role_reg <= role_next;
            fend_reg <= fend_next;
            mend_reg <= mend_next;
        end
    end

    assign result_valid    = valid_reg;
    assign byte_role       = role_reg;
    assign field_end       = fend_reg;
    assign message_end     = mend_reg;
    assign field_code      = code_reg;
    assign signature_count = count_reg;
    assign msg_identifier  = id_reg;
    assign body_bytes      = blen_reg;
    assign header_bytes    = hlen_reg;
    assign entry_bytes     = elen_reg;

endmodule

// File: src/bus_message_deframer_top.sv
// Channel   Words              Handshake
// input     data_byte          data_valid / data_stall
// output    byte_role .. end   result_valid / result_stall
//
// One word in and one result out per cycle when neither side stalls.
// A word is held first in the two-word input queue, then in the parser's
// result register. The parser's state update sets the rate.
// Reset is asynchronous; afterwards the parser expects a preheader.
// data_stall rises only when the queue is full; result_stall holds the result.
module bus_message_deframer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  byte_role,
    output logic [7:0]  field_code,
    output logic [7:0]  signature_count,
    output logic [31:0] msg_identifier,
    output logic [31:0] body_bytes,
    output logic [31:0] header_bytes,
    output logic [32:0] entry_bytes,
    output logic        field_end,
    output logic        message_end
);

    bmdf_pkg::queue_head_t head;
    logic                  pop;

    bmdf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (data_valid),
        .push_data  (data_byte),
        .full       (data_stall),
        .head       (head),
        .pop        (pop)
    );

    bmdf_parser u_parser
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .byte_role       (byte_role),
        .field_code      (field_code),
        .signature_count (signature_count),
        .msg_identifier  (msg_identifier),
        .body_bytes      (body_bytes),
        .header_bytes    (header_bytes),
        .entry_bytes     (entry_bytes),
        .field_end       (field_end),
        .message_end     (message_end)
    );

`ifndef ASSERT_OFF
    // A message ends on a header or body byte only together with its last field.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && message_end && byte_role != bmdf_pkg::ROLE_PRE |-> field_end)
        else $error("message end without field end");

    // Once past the preheader, the kept header length is a whole number of
    // eight-byte units; while the preheader arrives it still holds raw bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_role != bmdf_pkg::ROLE_PRE |-> header_bytes[2:0] == 3'd0)
        else $error("header length not rounded");

    // Preheader bytes never close a field.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_role == bmdf_pkg::ROLE_PRE |-> !field_end)
        else $error("field end on a preheader byte");

    // The queue only reads words that were pushed.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");
`endif

endmodule

// File: bench/tb_bus_message_deframer_top.sv
module tb_bus_message_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_WORDS = 1300;
    localparam int unsigned TX_IDLE[4]   = '{0, 52, 0, 35};
    localparam int unsigned RX_IDLE[4]   = '{0, 0, 52, 35};

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [3:0]  role;
        logic [7:0]  code;
        logic [7:0]  count;
        logic [31:0] ident;
        logic [31:0] body_len;
        logic [31:0] hdr_len;
        logic [32:0] entry_len;
        logic        fend;
        logic        mend;
    } byte_tag_t;

    class deframe_scoreboard;
        logic [1:0]  stage;
        logic [31:0] stage_pos;
        logic [32:0] fld_pos;
        logic [33:0] fld_total;
        logic [7:0]  code;
        logic [31:0] ident;
        logic [31:0] body_len;
        logic [31:0] hdr_len;
        logic [7:0]  count;
        logic [32:0] ent_len;
        byte_tag_t   tag_queue[$];
        int unsigned errors;

        function new();
            stage = bmdf_pkg::PH_PRE;
            stage_pos = '0;
            fld_pos = '0;
            fld_total = '0;
            code = '0;
            ident = '0;
            body_len = '0;
            hdr_len = '0;
            count = '0;
            ent_len = '0;
            errors = 0;
        endfunction

        function logic [33:0] round_up8(input logic [33:0] v);
            return (v + 34'(bmdf_pkg::ALIGN - 1)) & ~34'(bmdf_pkg::ALIGN - 1);
        endfunction

        function int pending();
            return tag_queue.size();
        endfunction

        // Works out the tag of one accepted word and queues it.
        function void note_byte(input logic [7:0] b);
            byte_tag_t   t;
            logic [33:0] p;
            logic [3:0]  slot;
            logic [31:0] raw_hdr;
            t = '0;
            t.role = bmdf_pkg::ROLE_PRE;
            case (stage)
                bmdf_pkg::PH_HDR:
                begin
                    p = {1'b0, fld_pos};
                    if (p == 0)
                    begin
                        code = b;
                        ent_len = '0;
                        fld_total = '0;
                        t.role = bmdf_pkg::ROLE_CODE;
                    end
                    else if (p < 4)
                        t.role = bmdf_pkg::ROLE_RESERVED;
                    else if (code == bmdf_pkg::SIG_CODE)
                    begin
                        if (p == 4)
                        begin
                            count = b;
                            ent_len = 33'(b) + 33'd1;
                            fld_total = round_up8(34'(b) + 34'd6);
                            t.role = bmdf_pkg::ROLE_SIGCOUNT;
                        end
                        else if (p < 34'(ent_len) + 34'd5)
                            t.role = bmdf_pkg::ROLE_SIG;
                        else
                            t.role = bmdf_pkg::ROLE_PAD;
                    end
                    else if (p < 8)
                    begin
                        t.role = bmdf_pkg::ROLE_STRLEN;
                        ent_len[32] = 1'b0;
                        ent_len[8 * p[1:0] +: 8] = b;
                        if (p == 7)
                        begin
                            ent_len = 33'(ent_len[31:0] & bmdf_pkg::LEN_MASK) + 33'd1;
                            fld_total = 34'd8 + round_up8(34'(ent_len));
                        end
                    end
                    else if (p < 34'(ent_len) + 34'd8)
                        t.role = bmdf_pkg::ROLE_STRING;
                    else
                        t.role = bmdf_pkg::ROLE_PAD;
                    fld_pos = 33'(p + 34'd1);
                    if (fld_total != 0 && {1'b0, fld_pos} >= fld_total)
                    begin
                        t.fend = 1'b1;
                        fld_pos = '0;
                    end
                    stage_pos = stage_pos + 32'd1;
                    if (stage_pos >= hdr_len)
                    begin
                        t.fend = 1'b1;
                        fld_pos = '0;
                        fld_total = '0;
                        stage_pos = '0;
                        if (body_len == 0)
                        begin
                            t.mend = 1'b1;
                            stage = bmdf_pkg::PH_PRE;
                        end
                        else
                            stage = bmdf_pkg::PH_BODY;
                    end
                end
                bmdf_pkg::PH_BODY:
                begin
                    p = {1'b0, fld_pos};
                    if (p < bmdf_pkg::LEN_FIELD)
                    begin
                        t.role = bmdf_pkg::ROLE_BODYLEN;
                        if (p == 0)
                        begin
                            ent_len = '0;
                            fld_total = '0;
                        end
                        ent_len[32] = 1'b0;
                        ent_len[8 * p[1:0] +: 8] = b;
                        if (p == bmdf_pkg::LEN_FIELD - 1)
                        begin
                            ent_len = 33'(ent_len[31:0] & bmdf_pkg::LEN_MASK) + 33'd1;
                            fld_total = 34'(ent_len) + 34'(bmdf_pkg::LEN_FIELD);
                        end
                    end
                    else
                        t.role = bmdf_pkg::ROLE_BODYDATA;
                    fld_pos = 33'(p + 34'd1);
                    if (fld_total != 0 && {1'b0, fld_pos} >= fld_total)
                    begin
                        t.fend = 1'b1;
                        fld_pos = '0;
                    end
                    stage_pos = stage_pos + 32'd1;
                    if (stage_pos >= body_len)
                    begin
                        t.fend = 1'b1;
                        t.mend = 1'b1;
                        fld_pos = '0;
                        fld_total = '0;
                        stage_pos = '0;
                        stage = bmdf_pkg::PH_PRE;
                    end
                end
                default:
                begin
                    // The first four preheader bytes carry nothing that is kept.
                    slot = stage_pos[3:0];
                    if (slot >= 4 && slot < 8)
                        body_len[8 * slot[1:0] +: 8] = b;
                    else if (slot >= 8 && slot < 12)
                        ident[8 * slot[1:0] +: 8] = b;
                    else if (slot >= 12)
                        hdr_len[8 * slot[1:0] +: 8] = b;
                    stage_pos = 32'(slot) + 32'd1;
                    if (slot == 4'(bmdf_pkg::PRE_BYTES - 1))
                    begin
                        raw_hdr = hdr_len & bmdf_pkg::LEN_MASK;
                        body_len = body_len & bmdf_pkg::LEN_MASK;
                        hdr_len = (raw_hdr > bmdf_pkg::HDR_MAX)
                                  ? bmdf_pkg::HDR_MAX
                                  : 32'(round_up8(34'(raw_hdr)));
                        stage_pos = '0;
                        fld_pos = '0;
                        fld_total = '0;
                        if (hdr_len != 0)
                            stage = bmdf_pkg::PH_HDR;
                        else if (body_len != 0)
                            stage = bmdf_pkg::PH_BODY;
                        else
                        begin
                            t.mend = 1'b1;
                            stage = bmdf_pkg::PH_PRE;
                        end
                    end
                end
            endcase
            t.code = code;
            t.count = count;
            t.ident = ident;
            t.body_len = body_len;
            t.hdr_len = hdr_len;
            t.entry_len = ent_len;
            tag_queue.push_back(t);
        endfunction

        function void check_result(input byte_tag_t got);
            byte_tag_t want;
            if (tag_queue.size() == 0)
            begin
                if (errors < 10)
                    $display("result word with no expectation waiting: %h", got);
                errors++;
                return;
            end
            want = tag_queue.pop_front();
            if (got.role !== want.role || got.code !== want.code ||
                got.count !== want.count || got.ident !== want.ident ||
                got.body_len !== want.body_len || got.hdr_len !== want.hdr_len ||
                got.entry_len !== want.entry_len || got.fend !== want.fend ||
                got.mend !== want.mend)
            begin
                if (errors < 10)
                    $display({"mismatch (expected/actual): role %0d/%0d code %h/%h ",
                              "count %h/%h id %h/%h body %h/%h header %h/%h ",
                              "entry %h/%h ends %b%b/%b%b"},
                             want.role, got.role, want.code, got.code,
                             want.count, got.count, want.ident, got.ident,
                             want.body_len, got.body_len, want.hdr_len, got.hdr_len,
                             want.entry_len, got.entry_len, want.fend, want.mend,
                             got.fend, got.mend);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [3:0]  byte_role;
    logic [7:0]  field_code;
    logic [7:0]  signature_count;
    logic [31:0] msg_identifier;
    logic [31:0] body_bytes;
    logic [31:0] header_bytes;
    logic [32:0] entry_bytes;
    logic        field_end;
    logic        message_end;

    deframe_scoreboard sb = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned words_sent = 0;
    int unsigned cycles = 0;

    bus_message_deframer_top uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_valid      (data_valid),
        .data_stall      (data_stall),
        .data_byte       (data_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .byte_role       (byte_role),
        .field_code      (field_code),
        .signature_count (signature_count),
        .msg_identifier  (msg_identifier),
        .body_bytes      (body_bytes),
        .header_bytes    (header_bytes),
        .entry_bytes     (entry_bytes),
        .field_end       (field_end),
        .message_end     (message_end)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // A requested hold-off keeps the result side stalled until the hold count runs out.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result({byte_role, field_code, signature_count, msg_identifier,
                             body_bytes, header_bytes, entry_bytes, field_end,
                             message_end});
    end

    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        sb.note_byte(b);
        words_sent++;
    endtask

    task automatic pause_sender();
        data_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_preheader(input logic [31:0] body_len, input logic [31:0] hdr_len);
        logic [31:0] ident;
        ident = $urandom();
        repeat (4) send_word(8'($urandom_range(255)));
        for (int i = 0; i < 4; i++)
            send_word(body_len[8 * i +: 8]);
        for (int i = 0; i < 4; i++)
            send_word(ident[8 * i +: 8]);
        for (int i = 0; i < 4; i++)
            send_word(hdr_len[8 * i +: 8]);
    endtask

    // Sends a message whose regions are as long as the preheader claims, with
    // the header rounded up to eight bytes; gaps are filled with random words.
    task automatic emit_message(input logic [31:0] hdr_len, input logic [31:0] body_len,
                                input byte_q_t hdr, input byte_q_t body);
        int unsigned hsize;
        hsize = ((hdr_len + bmdf_pkg::ALIGN - 1) / bmdf_pkg::ALIGN) * bmdf_pkg::ALIGN;
        send_preheader(body_len, hdr_len);
        for (int unsigned i = 0; i < hsize; i++)
            send_word((i < hdr.size()) ? hdr[i] : 8'($urandom_range(255)));
        for (int unsigned i = 0; i < body_len; i++)
            send_word((i < body.size()) ? body[i] : 8'($urandom_range(255)));
    endtask

    function automatic void add_sig_field(ref byte_q_t q, input logic [7:0] cnt);
        int unsigned start;
        start = q.size();
        q.push_back(bmdf_pkg::SIG_CODE);
        repeat (3) q.push_back(8'($urandom_range(255)));
        q.push_back(cnt);
        repeat (int'(cnt) + 1) q.push_back(8'($urandom_range(255)));
        while ((q.size() - start) % bmdf_pkg::ALIGN != 0)
            q.push_back(8'($urandom_range(255)));
    endfunction

    // Long strings are only started; the header end is expected to cut them off.
    function automatic void add_str_field(ref byte_q_t q, input logic [7:0] code,
                                          input logic [31:0] len);
        int unsigned start;
        start = q.size();
        q.push_back(code);
        repeat (3) q.push_back(8'($urandom_range(255)));
        for (int i = 0; i < 4; i++)
            q.push_back(len[8 * i +: 8]);
        repeat ((len < 64) ? len + 1 : 16) q.push_back(8'($urandom_range(255)));
        if (len < 64)
            while ((q.size() - start) % bmdf_pkg::ALIGN != 0)
                q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void add_entry(ref byte_q_t q, input logic [31:0] len);
        for (int i = 0; i < 4; i++)
            q.push_back(len[8 * i +: 8]);
        repeat ((len < 64) ? len + 1 : 12) q.push_back(8'($urandom_range(255)));
    endfunction

    // Mostly well-formed messages; the rest claim region lengths that cut fields
    // short or leave random words behind them.
    task automatic random_message();
        byte_q_t     hdr;
        byte_q_t     body;
        bit          broken;
        logic [7:0]  code;
        logic [31:0] hl;
        logic [31:0] bl;
        broken = ($urandom_range(4) == 0);
        repeat ($urandom_range(3))
        begin
            code = ($urandom_range(2) == 0) ? bmdf_pkg::SIG_CODE
                                            : 8'($urandom_range(255));
            if (code == bmdf_pkg::SIG_CODE)
                add_sig_field(hdr, ($urandom_range(39) == 0) ? 8'd255
                                                             : 8'($urandom_range(14)));
            else
                add_str_field(hdr, code, (broken && $urandom_range(2) == 0)
                                         ? $urandom() : $urandom_range(20));
        end
        repeat ($urandom_range(3))
            add_entry(body, (broken && $urandom_range(2) == 0)
                            ? $urandom() : $urandom_range(12));
        if (broken)
        begin
            if ($urandom_range(3) == 0)
                hdr.delete();
            hl = $urandom_range(hdr.size() + 12);
            bl = $urandom_range(body.size() + 8);
        end
        else
        begin
            hl = hdr.size();
            if (hl != 0)
                hl = hl - $urandom_range(bmdf_pkg::ALIGN - 1);
            bl = body.size();
        end
        emit_message(hl, bl, hdr, body);
    endtask

    initial
    begin
        byte_q_t     hdr;
        byte_q_t     body;
        int unsigned start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Preheader alone, then an empty header with one empty body entry.
        emit_message(0, 0, hdr, body);
        add_entry(body, 0);
        emit_message(0, body.size(), hdr, body);
        body.delete();

        // Signature and string fields with a header length that needs rounding.
        add_sig_field(hdr, 8'd0);
        add_str_field(hdr, 8'h00, 3);
        add_str_field(hdr, 8'hFF, 7);
        add_entry(body, 2);
        add_entry(body, 0);
        emit_message(hdr.size() - 5, body.size(), hdr, body);
        hdr.delete();
        body.delete();

        // Largest signature, and no body: the message ends on the last header word.
        add_sig_field(hdr, 8'd255);
        emit_message(hdr.size(), 0, hdr, body);
        hdr.delete();

        // Fields and entries running past the end of their region.
        add_str_field(hdr, 8'h01, 32'hFFFF_FFFF);
        add_entry(body, 32'hFFFF_FFFF);
        emit_message(16, 7, hdr, body);
        hdr.delete();
        body.delete();
        add_sig_field(hdr, 8'd40);
        add_entry(body, 5);
        emit_message(16, 2, hdr, body);
        hdr.delete();
        body.delete();
        add_str_field(hdr, 8'h07, 2);
        add_entry(body, 1);
        emit_message(8, 6, hdr, body);
        hdr.delete();
        body.delete();
        pause_sender();

        for (int k = 0; k < 4; k++)
        begin
            tx_idle_pct = TX_IDLE[k];
            rx_idle_pct = RX_IDLE[k];
            if (k >= 2)
                hold_request = 300;
            start = words_sent;
            while (words_sent - start < RANDOM_WORDS / 4)
                random_message();
            pause_sender();
        end

        // A header length near the top saturates; the stream then stays in the
        // header for the rest of the run.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_preheader(32'hFFFF_FFFF, $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFF9));
        repeat (40) send_word(8'($urandom_range(255)));
        pause_sender();
        repeat (4) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
src/bmdf_pkg.sv
src/bmdf_queue.sv
src/bmdf_parser.sv
src/bus_message_deframer_top.sv
bench/tb_bus_message_deframer_top.sv
